// ===== rtl/ili_pkg.sv =====
// ----------------------------------------------------------------------------
// ili_pkg: shared types and codes for the indexed list
// Command and result word layouts, command and status codes, shift ops.
// ----------------------------------------------------------------------------
`default_nettype none

package ili_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_GET  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic signed [VAL_W-1:0] VAL_BAD = -32'sd1;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_INS,
        SHIFT_DEL
    } t_shift_op;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [STAT_W-1:0]       status;
        logic [COUNT_W-1:0]      count;
    } t_rsp_word;

endpackage

`default_nettype wire

// ===== rtl/ili_cell.sv =====
// ----------------------------------------------------------------------------
// ili_cell: one list slot
// Holds one entry; takes its left neighbor on insert, its right on delete.
// ----------------------------------------------------------------------------
`default_nettype none

module ili_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7
) (
    input  wire logic                             i_clk,
    input  wire ili_pkg::t_shift_op               i_op,
    input  wire logic [PW-1:0]                    i_pos,
    input  wire logic signed [ili_pkg::VAL_W-1:0] i_value,
    input  wire logic signed [ili_pkg::VAL_W-1:0] i_left,
    input  wire logic signed [ili_pkg::VAL_W-1:0] i_right,
    output logic signed [ili_pkg::VAL_W-1:0]      o_value,
    output logic signed [ili_pkg::VAL_W-1:0]      o_hit
);
    import ili_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            SHIFT_INS: begin
                if (MY_IDX == i_pos) begin
                    n_entry = i_value;
                end else if (MY_IDX > i_pos) begin
                    n_entry = i_left;
                end
            end
            SHIFT_DEL: begin
                if (MY_IDX >= i_pos) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_value = r_entry;
    assign o_hit   = (MY_IDX == i_pos) ? r_entry : '0;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered list with indexed insert, delete, get
// A row of CAPACITY slot cells shifts up or down on each insert or delete command.
// ----------------------------------------------------------------------------
//
//  channel   valid     ready     word           direction
//  command   i_valid   o_ready   i_cmd (t_cmd)  in
//  result    o_valid   i_ready   o_rsp (t_rsp)  out
//
// One command is taken per cycle while the result side keeps up; its result
// appears in the output register on the next cycle. Every cell compares its own
// index against the command position and shifts or holds in parallel, so a whole
// insert or delete completes as the command is taken. A get selects the addressed cell through a one-hot AND-OR.
// Reset clears only the count and the output valid; entries hold garbage
// until written. The command side stalls only while a result waits unread.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete #(
    parameter int CAPACITY = ili_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire ili_pkg::t_cmd_word i_cmd,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output ili_pkg::t_rsp_word      o_rsp
);
    import ili_pkg::*;

    // count holds 0..CAPACITY; compare width covers count and the port index
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_rsp_word     r_out_word;

    logic                    w_take;
    t_shift_op               w_op;
    t_shift_op               w_cell_op;
    logic [PW-1:0]           w_pos;
    logic [PW-1:0]           w_pos_ext;
    logic [PW-1:0]           w_count_ext;
    logic [STAT_W-1:0]       w_status;
    logic                    w_get_ok;
    logic signed [VAL_W-1:0] w_read;
    logic signed [VAL_W-1:0] w_read_out;
    logic signed [VAL_W-1:0] w_sel;

    logic signed [VAL_W-1:0] w_val [CAPACITY];
    logic signed [VAL_W-1:0] w_hit [CAPACITY];

    // take a command whenever the output register is empty or draining
    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    assign w_pos_ext   = PW'(i_cmd.position);
    assign w_count_ext = PW'(r_count);

    // merge the one-hot cell reads
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel = w_sel | w_hit[i];
        end
    end

    // decode the command into a shift op, status, read value and new count
    always_comb begin
        logic do_ins;
        logic [PW-1:0] ins_pos;
        do_ins   = 1'b0;
        ins_pos  = '0;
        w_op     = SHIFT_HOLD;
        w_pos    = w_pos_ext;
        w_status = ST_DONE;
        w_get_ok = 1'b0;
        w_read   = '0;
        n_count  = r_count;
        unique case (i_cmd.command)
            CMD_GET: begin
                if (w_pos_ext < w_count_ext) begin
                    w_get_ok = 1'b1;
                end else begin
                    w_read   = VAL_BAD;
                    w_status = ST_BAD_INDEX;
                end
            end
            CMD_HEAD: begin
                do_ins  = 1'b1;
                ins_pos = '0;
            end
            CMD_TAIL: begin
                do_ins  = 1'b1;
                ins_pos = w_count_ext;
            end
            CMD_AT: begin
                if (w_pos_ext > w_count_ext) begin
                    w_status = ST_BAD_INDEX;
                end else begin
                    do_ins  = 1'b1;
                    ins_pos = w_pos_ext;
                end
            end
            CMD_DEL: begin
                if (w_pos_ext < w_count_ext) begin
                    w_op    = SHIFT_DEL;
                    n_count = r_count - CW'(1);
                end else begin
                    w_status = ST_BAD_INDEX;
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
        if (do_ins) begin
            // refuse an insert once every slot is taken
            if (w_count_ext >= PW'(CAPACITY)) begin
                w_status = ST_FULL;
            end else begin
                w_op    = SHIFT_INS;
                w_pos   = ins_pos;
                n_count = r_count + CW'(1);
            end
        end
    end

    // a good get takes the addressed cell, every other command the decoded value
    assign w_read_out = w_get_ok ? w_sel : w_read;

    // hold every cell unless a command is taken this cycle
    assign w_cell_op = w_take ? w_op : SHIFT_HOLD;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        ili_cell #(
            .IDX (g),
            .PW  (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_pos   (w_pos),
            .i_value (i_cmd.value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[g]),
            .o_hit   (w_hit[g])
        );
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count <= n_count;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word: load on take, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_word.read_value <= w_read_out;
            r_out_word.status     <= w_status;
            r_out_word.count      <= COUNT_W'(n_count);
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_word;

endmodule

`default_nettype wire

// ===== bench/list_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_result_checker: result predictor and comparator for the indexed list
// Watches both channels, keeps a positional copy of the list and compares each
// result word, field by field, against the oldest predicted word.
// ----------------------------------------------------------------------------

module list_result_checker #(
    parameter int CAPACITY = ili_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  logic               i_cmd_ready,
    input  ili_pkg::t_cmd_word i_cmd,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  ili_pkg::t_rsp_word i_rsp,
    output int                 o_pending,
    output int                 o_fail_count
);

    import ili_pkg::*;

    // keep the log short when the block is badly broken
    localparam int REPORT_LINES = 40;

    logic signed [VAL_W-1:0] slots [CAPACITY];
    int                      slot_count = 0;
    t_rsp_word               predicted_q [$];
    int                      pending_n  = 0;
    int                      mismatches = 0;
    int                      result_idx = 0;

    assign o_pending    = pending_n;
    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < REPORT_LINES) begin
            $display("[%0t] result %0d: %s got %0h expected %0h",
                     $time, result_idx, what, got, want);
        end
        mismatches++;
    endtask

    // Apply one command word to the list copy and build the result it gives.
    task automatic apply_list_command(input t_cmd_word w, output t_rsp_word r);
        int                      pos;
        int                      ins_pos;
        logic                    ins;
        logic signed [VAL_W-1:0] rd;
        logic [STAT_W-1:0]       st;
        pos     = int'(w.position);
        ins_pos = 0;
        ins     = 1'b0;
        rd      = '0;
        st      = ST_DONE;
        case (w.command)
            CMD_GET: begin
                if (pos < slot_count) begin
                    rd = slots[pos];
                end else begin
                    rd = VAL_BAD;
                    st = ST_BAD_INDEX;
                end
            end
            CMD_HEAD: begin
                ins     = 1'b1;
                ins_pos = 0;
            end
            CMD_TAIL: begin
                ins     = 1'b1;
                ins_pos = slot_count;
            end
            CMD_AT: begin
                // index check wins over the full check
                if (pos > slot_count) begin
                    st = ST_BAD_INDEX;
                end else begin
                    ins     = 1'b1;
                    ins_pos = pos;
                end
            end
            CMD_DEL: begin
                if (pos < slot_count) begin
                    for (int i = pos; i + 1 < slot_count; i++) slots[i] = slots[i + 1];
                    slot_count--;
                end else begin
                    st = ST_BAD_INDEX;
                end
            end
            default: begin
            end
        endcase
        if (ins) begin
            if (slot_count >= CAPACITY) begin
                st = ST_FULL;
            end else begin
                for (int i = slot_count; i > ins_pos; i--) slots[i] = slots[i - 1];
                slots[ins_pos] = w.value;
                slot_count++;
            end
        end
        r.read_value = rd;
        r.status     = st;
        r.count      = COUNT_W'(slot_count);
    endtask

    always @(posedge i_clk) begin
        t_rsp_word oldest;
        t_rsp_word fresh;
        if (!i_rst_n) begin
            slot_count = 0;
            predicted_q.delete();
            pending_n <= 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (predicted_q.size() == 0) begin
                    report_mismatch("result with nothing pending", i_rsp.read_value, '0);
                end else begin
                    oldest = predicted_q.pop_front();
                    if (i_rsp.read_value !== oldest.read_value)
                        report_mismatch("read_value", i_rsp.read_value, oldest.read_value);
                    if (i_rsp.status !== oldest.status)
                        report_mismatch("status", 32'(i_rsp.status), 32'(oldest.status));
                    if (i_rsp.count !== oldest.count)
                        report_mismatch("count", 32'(i_rsp.count), 32'(oldest.count));
                end
                result_idx++;
            end
            if (i_cmd_valid && i_cmd_ready) begin
                apply_list_command(i_cmd, fresh);
                predicted_q.push_back(fresh);
            end
            pending_n <= predicted_q.size();
        end
    end

endmodule

// ===== bench/indexed_list_insert_delete_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_tb: stimulus and verdict for the indexed list
// Drives directed and phased random command words in bursts, stalls the
// result side, and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------

module indexed_list_insert_delete_tb;

    import ili_pkg::*;

    localparam int CAPACITY       = CAPACITY_DEF;
    localparam int RANDOM_WORDS   = 1130;
    // long enough for a fill phase to reach a full list and a drain to empty it
    localparam int PHASE_LEN      = 160;
    localparam int MAX_GAP        = 20;
    localparam int MAX_BURST      = 40;
    // margin past the result register
    localparam int DRAIN_CYCLES   = 8;
    // far above the longest sender gap plus the longest receiver stall
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    t_cmd_word cmd_word  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    t_rsp_word rsp_word;
    int        pending;
    int        fail_count;

    // Stimulus-side view of the list length, used only to aim positions.
    int list_len    = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_mode  = 0;

    always #2 i_clk = ~i_clk;

    indexed_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(cmd_valid),
        .o_ready(cmd_ready),
        .i_cmd  (cmd_word),
        .o_valid(rsp_valid),
        .i_ready(rsp_ready),
        .o_rsp  (rsp_word)
    );

    list_result_checker #(
        .CAPACITY(CAPACITY)
    ) u_result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .i_cmd       (cmd_word),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_rsp       (rsp_word),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    function automatic t_cmd_word cmd_of(input logic [CMD_W-1:0] c, input int p,
                                         input logic [VAL_W-1:0] v);
        t_cmd_word w;
        w.command  = c;
        w.position = POS_W'(p);
        w.value    = v;
        return w;
    endfunction

    // Pick a live index; on an empty list fall back to zero, a bad index.
    function automatic int pick_below(input int n);
        return (n == 0) ? 0 : int'($urandom_range(0, n - 1));
    endfunction

    // Build one random command word. Most words are well formed for the
    // current length; a small share is noise: any code, any position.
    function automatic t_cmd_word random_cmd(input t_phase ph, input int len);
        int                 roll;
        int                 ins_w;
        int                 del_w;
        logic [VAL_W-1:0]   v;
        v    = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            return cmd_of(CMD_W'($urandom), $urandom_range(0, 127), v);
        end
        // bias the mix so the list swings between empty and full
        case (ph)
            PH_FILL: begin
                ins_w = 65;
                del_w = 10;
            end
            PH_DRAIN: begin
                ins_w = 15;
                del_w = 60;
            end
            default: begin
                ins_w = 35;
                del_w = 30;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_w) begin
            case ($urandom_range(0, 2))
                0:       return cmd_of(CMD_HEAD, $urandom_range(0, 127), v);
                1:       return cmd_of(CMD_TAIL, $urandom_range(0, 127), v);
                default: return cmd_of(CMD_AT, $urandom_range(0, len), v);
            endcase
        end else if (roll < ins_w + del_w) begin
            return cmd_of(CMD_DEL, pick_below(len), v);
        end
        return cmd_of(CMD_GET, pick_below(len), v);
    endfunction

    // Offer one word and hold it until accepted. Bursts of back-to-back words
    // alternate with random gaps; inside a burst valid stays high.
    task automatic send_word(input t_cmd_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, MAX_BURST);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge i_clk);
        while (!cmd_ready) @(posedge i_clk);
        burst_left--;
        // track the length so later positions land inside the list
        case (w.command)
            CMD_HEAD, CMD_TAIL: begin
                if (list_len < CAPACITY) list_len++;
            end
            CMD_AT: begin
                if (int'(w.position) <= list_len && list_len < CAPACITY) list_len++;
            end
            CMD_DEL: begin
                if (int'(w.position) < list_len) list_len--;
            end
            default: begin
            end
        endcase
    endtask

    // Result side: stretches of always ready, light stalls, coin flips and
    // heavy stalls, each stretch of random length.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(10, 150);
            stall_mode = $urandom_range(0, 3);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_cmd_word directed [$];
        t_phase    ph;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: get, delete and insert at a position all miss.
        directed.push_back(cmd_of(CMD_GET, 0, '0));
        directed.push_back(cmd_of(CMD_GET, 127, '1));
        directed.push_back(cmd_of(CMD_DEL, 0, '0));
        directed.push_back(cmd_of(CMD_AT, 1, 32'h1234_5678));
        directed.push_back(cmd_of(CMD_AT, 127, 32'h7fff_ffff));
        // Build four entries through every insert flavor, value extremes.
        directed.push_back(cmd_of(CMD_HEAD, 0, 32'h7fff_ffff));
        directed.push_back(cmd_of(CMD_TAIL, 127, 32'h8000_0000));
        directed.push_back(cmd_of(CMD_AT, 1, '1));
        directed.push_back(cmd_of(CMD_AT, 3, '0));
        // Read every live entry, then one past the end.
        directed.push_back(cmd_of(CMD_GET, 0, '1));
        directed.push_back(cmd_of(CMD_GET, 1, '0));
        directed.push_back(cmd_of(CMD_GET, 2, '1));
        directed.push_back(cmd_of(CMD_GET, 3, '0));
        directed.push_back(cmd_of(CMD_GET, 4, '0));
        // Unused codes leave the list alone.
        directed.push_back(cmd_of(CMD_W'(CMD_DEL + 1), 127, '1));
        directed.push_back(cmd_of(CMD_W'(CMD_DEL + 2), 0, 32'h8000_0000));
        directed.push_back(cmd_of(CMD_W'(CMD_DEL + 3), 127, 32'h7fff_ffff));
        // Delete the tail, then the head, then miss past the end.
        directed.push_back(cmd_of(CMD_DEL, 3, '1));
        directed.push_back(cmd_of(CMD_DEL, 0, '1));
        directed.push_back(cmd_of(CMD_DEL, 2, '0));
        directed.push_back(cmd_of(CMD_GET, 1, '0));

        foreach (directed[k]) send_word(directed[k]);

        // Random part: fill, drain and mixed phases in turn.
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            ph = t_phase'((k / PHASE_LEN) % 3);
            send_word(random_cmd(ph, list_len));
        end
        cmd_valid <= 1'b0;

        // Drain: let the checker count the last word, wait for every
        // predicted word, then a little longer.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
